// ===== design/eurf_pkg.sv =====
// Shared types and constants for the encoder unwrap and rate filter block.
// No dependencies; imported by eurf_step_cell and encoder_unwrap_rate_filter.
`default_nettype none
package eurf_pkg;

    localparam int ANGLE_W = 13;
    localparam int STEP_W  = 14;
    localparam int TURNS_W = 24;
    localparam int POS_W   = 38;
    localparam int DEG_W   = 46;
    localparam int WORD_W  = 16;

    typedef logic        [ANGLE_W-1:0] t_angle;
    typedef logic signed [STEP_W-1:0]  t_step;
    typedef logic signed [TURNS_W-1:0] t_turns;
    typedef logic signed [POS_W-1:0]   t_pos;
    typedef logic signed [DEG_W-1:0]   t_deg;
    typedef logic signed [WORD_W-1:0]  t_word;

    localparam t_step  HALF_TURN_POS = 14'sd4096;
    localparam t_step  HALF_TURN_NEG = -14'sd4096;
    localparam t_step  FULL_TURN     = 14'h2000;
    localparam t_turns TURN_MAX      = 24'sh7FFFFF;
    localparam t_turns TURN_MIN      = 24'sh800000;

endpackage
`default_nettype wire

// ===== design/encoder_unwrap_rate_filter.sv =====
// Top level: multi-turn unwrap, step history chain, averaged rate and degree output.
// Depends on eurf_pkg and eurf_step_cell.
//
//   channel | valid    | stall    | payload
//   --------+----------+----------+--------------------------------------------------
//   request | i_valid  | o_stall  | i_capture_bias i_raw_angle i_speed_rpm i_torque_current
//   result  | o_valid  | i_stall  | o_position o_turn_count o_step_rate o_filtered_rate
//           |          |          | o_angle_deg_q13 o_speed_out o_current_out
//
// One request per cycle while o_stall is low; results pass stage A and the output stage.
// Unwrap state and the step chain update in the accept cycle (no shift on a bias
// capture); stage two holds the reciprocal multiply for averaging and the degree scaling.
// Synchronous active-low reset clears all but payload registers at once; no clearing pass.
// A stalled result holds; requests keep flowing until both stages are full.
`default_nettype none
module encoder_unwrap_rate_filter #(
    parameter int RING_DEPTH = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire                 i_capture_bias,
    input  eurf_pkg::t_angle    i_raw_angle,
    input  eurf_pkg::t_word     i_speed_rpm,
    input  eurf_pkg::t_word     i_torque_current,
    output logic                o_valid,
    input  wire                 i_stall,
    output eurf_pkg::t_pos      o_position,
    output eurf_pkg::t_turns    o_turn_count,
    output eurf_pkg::t_step     o_step_rate,
    output eurf_pkg::t_step     o_filtered_rate,
    output eurf_pkg::t_deg      o_angle_deg_q13,
    output eurf_pkg::t_word     o_speed_out,
    output eurf_pkg::t_word     o_current_out
);
    import eurf_pkg::*;

    localparam int SUM_W = $clog2(RING_DEPTH * 4096 + 1) + 1;
    localparam int MAG_W = SUM_W - 1;
    localparam int DW    = $clog2(RING_DEPTH) + 1;
    localparam int K     = MAG_W + DW;
    localparam logic [K:0] RECIP = (K+1)'((64'd1 << K) / RING_DEPTH + 64'd1);
    localparam int PROD_W = MAG_W + K + 1;

    logic en_a;
    logic en_o;
    logic acc;

    t_angle r_prev;
    t_angle r_bias;
    t_turns r_turns;
    logic signed [SUM_W-1:0] r_sum;

    t_angle n_prev;
    t_angle n_bias;
    t_turns n_turns;
    logic signed [SUM_W-1:0] n_sum;
    t_step  n_step;
    t_step  diff;
    t_pos   n_pos;
    t_pos   n_rel;
    logic   shift;

    t_step chain [RING_DEPTH+1];

    logic                    r_a_valid;
    t_pos                    r_a_pos;
    t_pos                    r_a_rel;
    t_turns                  r_a_turns;
    t_step                   r_a_step;
    logic signed [SUM_W-1:0] r_a_sum;
    t_word                   r_a_speed;
    t_word                   r_a_current;

    logic [MAG_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    t_step             quot;
    t_step             n_filt;
    t_deg              rel_x;
    t_deg              n_deg;

    logic   r_o_valid;
    t_pos   r_o_pos;
    t_turns r_o_turns;
    t_step  r_o_step;
    t_step  r_o_filt;
    t_deg   r_o_deg;
    t_word  r_o_speed;
    t_word  r_o_current;

    assign en_o    = !r_o_valid || !i_stall;
    assign en_a    = !r_a_valid || en_o;
    assign o_stall = !en_a;
    assign acc     = i_valid && en_a;
    assign shift   = acc && !i_capture_bias;

    // unwrap
    always_comb begin
        diff    = t_step'({1'b0, i_raw_angle}) - t_step'({1'b0, r_prev});
        n_turns = r_turns;
        n_bias  = r_bias;
        n_prev  = i_raw_angle;
        n_step  = '0;
        n_sum   = r_sum;
        if (i_capture_bias) begin
            n_bias = i_raw_angle;
        end else begin
            if (diff < HALF_TURN_NEG) begin
                n_step = diff + FULL_TURN;
                if (r_turns != TURN_MAX) begin
                    n_turns = r_turns + 24'sd1;
                end
            end else if (diff > HALF_TURN_POS) begin
                n_step = diff - FULL_TURN;
                if (r_turns != TURN_MIN) begin
                    n_turns = r_turns - 24'sd1;
                end
            end else begin
                n_step = diff;
            end
            n_sum = r_sum + SUM_W'(n_step) - SUM_W'(chain[RING_DEPTH]);
        end
        n_pos = {n_turns[TURNS_W-1], n_turns, i_raw_angle};
        n_rel = n_pos - t_pos'({1'b0, n_bias});
    end

    assign chain[0] = n_step;

    genvar g;
    generate
        for (g = 0; g < RING_DEPTH; g++) begin : g_cell
            eurf_step_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_step  (chain[g]),
                .o_step  (chain[g+1])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_bias  <= '0;
            r_turns <= '0;
            r_sum   <= '0;
        end else if (acc) begin
            r_prev  <= n_prev;
            r_bias  <= n_bias;
            r_turns <= n_turns;
            r_sum   <= n_sum;
        end
    end

    // stage A
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en_a) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a_pos     <= n_pos;
            r_a_rel     <= n_rel;
            r_a_turns   <= n_turns;
            r_a_step    <= n_step;
            r_a_sum     <= n_sum;
            r_a_speed   <= i_speed_rpm;
            r_a_current <= i_torque_current;
        end
    end

    // average and degree scaling
    always_comb begin
        mag    = r_a_sum[SUM_W-1] ? MAG_W'(-r_a_sum) : MAG_W'(r_a_sum);
        prod   = PROD_W'(mag) * PROD_W'(RECIP);
        quot   = prod[K +: STEP_W];
        n_filt = r_a_sum[SUM_W-1] ? -quot : quot;
        rel_x  = DEG_W'(r_a_rel);
        n_deg  = (rel_x <<< 8) + (rel_x <<< 6) + (rel_x <<< 5) + (rel_x <<< 3);
    end

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en_o) begin
            r_o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o && r_a_valid) begin
            r_o_pos     <= r_a_pos;
            r_o_turns   <= r_a_turns;
            r_o_step    <= r_a_step;
            r_o_filt    <= n_filt;
            r_o_deg     <= n_deg;
            r_o_speed   <= r_a_speed;
            r_o_current <= r_a_current;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_position      = r_o_pos;
    assign o_turn_count    = r_o_turns;
    assign o_step_rate     = r_o_step;
    assign o_filtered_rate = r_o_filt;
    assign o_angle_deg_q13 = r_o_deg;
    assign o_speed_out     = r_o_speed;
    assign o_current_out   = r_o_current;

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_a_valid && r_o_valid))
        else $error("request stalled with a free stage");

    a_capture_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_capture_bias) |=> (r_prev == r_bias))
        else $error("capture did not align previous angle and bias");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> (r_a_step <= HALF_TURN_POS && r_a_step >= HALF_TURN_NEG))
        else $error("step outside half a turn");

    a_turn_delta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> (r_turns == $past(r_turns) || r_turns == $past(r_turns) + 24'sd1 ||
                 r_turns == $past(r_turns) - 24'sd1))
        else $error("turn count moved by more than one");

    a_sum_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !shift |=> (r_sum == $past(r_sum)))
        else $error("ring sum changed without a step");

endmodule
`default_nettype wire

// ===== design/eurf_step_cell.sv =====
// One cell of the step history chain: holds one step, passes it on when shifted.
// Depends on eurf_pkg.
`default_nettype none
module eurf_step_cell (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_shift,
    input  eurf_pkg::t_step i_step,
    output eurf_pkg::t_step o_step
);
    import eurf_pkg::*;

    t_step r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_shift) begin
            r_step <= i_step;
        end
    end

    assign o_step = r_step;

endmodule
`default_nettype wire

// ===== tb/encoder_unwrap_rate_filter_test.sv =====
// Testbench for encoder_unwrap_rate_filter: directed and random encoder samples,
// scored against an in-bench unwrap and ring-average tracker.
// Depends on eurf_pkg and the encoder_unwrap_rate_filter RTL.
`timescale 1ns / 100ps
module encoder_unwrap_rate_filter_test;
    import eurf_pkg::*;

    localparam int RING_DEPTH       = 8;
    localparam int HALF_TURN        = 4096;
    localparam int COUNTS_PER_TURN  = 8192;
    localparam int DEG_PER_TURN     = 360;
    localparam int RANDOM_PER_PHASE = 230;
    localparam int SETTLE_CYCLES    = 8;

    typedef struct {
        t_pos   position;
        t_turns turn_count;
        t_step  step_rate;
        t_step  filtered_rate;
        t_deg   angle_deg_q13;
        t_word  speed_out;
        t_word  current_out;
    } track_result_t;

    class encoder_track_scoreboard;
        t_angle        prev_angle;
        t_angle        zero_bias;
        int            turns;
        int            ring_sum;
        int            ring_idx;
        int            step_ring[RING_DEPTH];
        track_result_t expected_samples[$];
        int            failures;

        function new();
            prev_angle = '0;
            zero_bias  = '0;
            turns      = 0;
            ring_sum   = 0;
            ring_idx   = 0;
            failures   = 0;
            foreach (step_ring[k]) step_ring[k] = 0;
        endfunction

        function void note_request(bit capture, t_angle raw, t_word speed, t_word current);
            int            diff;
            int            step;
            track_result_t want;
            step = 0;
            if (capture) begin
                zero_bias  = raw;
                prev_angle = raw;
            end else begin
                diff = int'(raw) - int'(prev_angle);
                if (diff < -HALF_TURN) begin
                    if (turns < TURN_MAX) turns++;
                    step = diff + COUNTS_PER_TURN;
                end else if (diff > HALF_TURN) begin
                    if (turns > TURN_MIN) turns--;
                    step = diff - COUNTS_PER_TURN;
                end else begin
                    step = diff;
                end
                prev_angle = raw;
                if (ring_idx >= RING_DEPTH) ring_idx = 0;
                ring_sum += step - step_ring[ring_idx];
                step_ring[ring_idx] = step;
                ring_idx++;
                if (ring_idx >= RING_DEPTH) ring_idx = 0;
            end
            want.position      = t_pos'(longint'(raw) + longint'(turns) * COUNTS_PER_TURN);
            want.turn_count    = t_turns'(turns);
            want.step_rate     = t_step'(step);
            want.filtered_rate = t_step'(ring_sum / RING_DEPTH);
            want.angle_deg_q13 = t_deg'((longint'(raw) - longint'(zero_bias)
                                 + longint'(turns) * COUNTS_PER_TURN) * DEG_PER_TURN);
            want.speed_out     = speed;
            want.current_out   = current;
            expected_samples.push_back(want);
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                $error("%s expected %0d got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(track_result_t got);
            track_result_t want;
            if (expected_samples.size() == 0) begin
                $error("result with no outstanding request");
                failures++;
                return;
            end
            want = expected_samples.pop_front();
            compare_field("position", want.position, got.position);
            compare_field("turn_count", want.turn_count, got.turn_count);
            compare_field("step_rate", want.step_rate, got.step_rate);
            compare_field("filtered_rate", want.filtered_rate, got.filtered_rate);
            compare_field("angle_deg_q13", want.angle_deg_q13, got.angle_deg_q13);
            compare_field("speed_out", want.speed_out, got.speed_out);
            compare_field("current_out", want.current_out, got.current_out);
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_stall;
    logic   i_capture_bias;
    t_angle i_raw_angle;
    t_word  i_speed_rpm;
    t_word  i_torque_current;
    logic   o_valid;
    logic   i_stall;
    t_pos   o_position;
    t_turns o_turn_count;
    t_step  o_step_rate;
    t_step  o_filtered_rate;
    t_deg   o_angle_deg_q13;
    t_word  o_speed_out;
    t_word  o_current_out;

    encoder_track_scoreboard sb;
    int     send_idle_pct = 17;
    int     recv_idle_pct = 49;
    t_angle last_raw;

    encoder_unwrap_rate_filter #(
        .RING_DEPTH(RING_DEPTH)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_capture_bias  (i_capture_bias),
        .i_raw_angle     (i_raw_angle),
        .i_speed_rpm     (i_speed_rpm),
        .i_torque_current(i_torque_current),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_position      (o_position),
        .o_turn_count    (o_turn_count),
        .o_step_rate     (o_step_rate),
        .o_filtered_rate (o_filtered_rate),
        .o_angle_deg_q13 (o_angle_deg_q13),
        .o_speed_out     (o_speed_out),
        .o_current_out   (o_current_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        track_result_t got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.position      = o_position;
            got.turn_count    = o_turn_count;
            got.step_rate     = o_step_rate;
            got.filtered_rate = o_filtered_rate;
            got.angle_deg_q13 = o_angle_deg_q13;
            got.speed_out     = o_speed_out;
            got.current_out   = o_current_out;
            sb.check_result(got);
        end
    end

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(bit capture, t_angle raw, t_word speed, t_word current);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_capture_bias   <= capture;
        i_raw_angle      <= raw;
        i_speed_rpm      <= speed;
        i_torque_current <= current;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(capture, raw, speed, current);
        last_raw = raw;
        @(negedge i_clk);
    endtask

    task automatic send_random_sample();
        int     pick;
        int     delta;
        bit     capture;
        t_angle raw;
        pick    = $urandom_range(99);
        capture = (pick < 4);
        if (capture || pick >= 80) begin
            raw = t_angle'($urandom_range(COUNTS_PER_TURN - 1));
        end else if (pick < 62) begin
            delta = $urandom_range(1200) - 500;
            raw   = t_angle'(int'(last_raw) + delta);
        end else begin
            delta = HALF_TURN - 6 + $urandom_range(12);
            if ($urandom_range(1)) delta = -delta;
            raw = t_angle'(int'(last_raw) + delta);
        end
        send_request(capture, raw, t_word'($urandom_range(16'hFFFF)),
                     t_word'($urandom_range(16'hFFFF)));
    endtask

    // hold the sender until every outstanding result is back
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    initial begin
        sb               = new();
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_capture_bias   = 1'b0;
        i_raw_angle      = '0;
        i_speed_rpm      = '0;
        i_torque_current = '0;
        last_raw         = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_request(1'b0, 13'd0,    16'h7FFF, 16'h8000);
        send_request(1'b0, 13'd4096, 16'h8000, 16'h7FFF);
        send_request(1'b0, 13'd0,    16'h0000, 16'hFFFF);
        send_request(1'b0, 13'd4097, 16'hFFFF, 16'h0000);
        send_request(1'b0, 13'd0,    16'h0001, 16'h8000);
        send_request(1'b0, 13'd8191, 16'h7FFF, 16'h0001);
        send_request(1'b0, 13'd0,    16'h8000, 16'h7FFF);
        send_request(1'b0, 13'd8191, 16'h0000, 16'h0000);
        send_request(1'b0, 13'd4095, 16'hFFFF, 16'hFFFF);
        send_request(1'b1, 13'd1234, 16'h8000, 16'h7FFF);
        send_request(1'b0, 13'd1300, 16'h7FFF, 16'h8000);
        send_request(1'b0, 13'd1200, 16'h1234, 16'hEDCB);
        send_request(1'b0, 13'd1195, 16'h5555, 16'hAAAA);
        send_request(1'b1, 13'd8191, 16'hAAAA, 16'h5555);
        send_request(1'b0, 13'd0,    16'h0000, 16'h0000);
        send_request(1'b0, 13'd8000, 16'hFFFF, 16'h0001);
        send_request(1'b0, 13'd7990, 16'h0001, 16'hFFFF);
        send_request(1'b1, 13'd0,    16'h7FFF, 16'h7FFF);
        send_request(1'b0, 13'd4096, 16'h8000, 16'h8000);
        send_request(1'b0, 13'd8191, 16'h0000, 16'h0000);
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 49 : 0;
            recv_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 17 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++) send_random_sample();
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
